// ===== hw/rtl/vertex_attribute_transform_top_macros.svh =====
// ----------------------------------------------------------------------------
// vertex attribute transform assertion macros
// property wrappers clocked on clk_i and disabled during reset
// ----------------------------------------------------------------------------
`ifndef VERTEX_ATTRIBUTE_TRANSFORM_TOP_MACROS_SVH
`define VERTEX_ATTRIBUTE_TRANSFORM_TOP_MACROS_SVH

// consequent must hold whenever antecedent holds
`define VAT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition must never hold
`define VAT_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// ===== hw/rtl/vat_pkg.sv =====
// ----------------------------------------------------------------------------
// vat_pkg
// shared types, constants and helpers of the vertex attribute transform
// ----------------------------------------------------------------------------
`default_nettype none

package vat_pkg;

  localparam int unsigned AddrW     = 6;
  localparam int unsigned DataW     = 64;
  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned DivSteps  = 15;
  // products, round, squares, sum, root, numerator, divide, sign
  localparam int unsigned DirLat    = 4 + SqrtSteps + 1 + DivSteps + 1;

  localparam logic [47:0]        Len2Min     = 48'd43;
  localparam logic signed [15:0] UnitQ14     = 16'sd16384;
  localparam logic [1:0]         TanSignNone = 2'b00;
  localparam logic [1:0]         TanSignPos  = 2'b01;
  localparam logic [1:0]         TanSignNeg  = 2'b11;

  typedef enum logic [2:0] {
    REG_WORLD0 = 3'd0,
    REG_WORLD1 = 3'd1,
    REG_WORLD2 = 3'd2,
    REG_TXY    = 3'd3,
    REG_TZ     = 3'd4,
    REG_NRM0   = 3'd5,
    REG_NRM1   = 3'd6,
    REG_NRM2   = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [2:0][47:0] world;
    logic [47:0]      txy;
    logic [23:0]      tz;
    logic [2:0][47:0] nrm;
  } cfg_t;

  typedef struct packed {
    logic ld;   // first stage takes a new item
    logic adv;  // all later stages advance
  } pipe_ctrl_t;

  function automatic logic signed [15:0] mat_entry(logic [47:0] row, logic [1:0] col);
    logic signed [15:0] e;
    case (col)
      2'd0:    e = row[47:32];
      2'd1:    e = row[31:16];
      default: e = row[15:0];
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/vertex_attribute_transform_top.sv =====
// throughput: one item per cycle while the output is not stalled, set by the fully pipelined divide and root
// a stalled output holds the whole pipeline; an empty first stage still loads
// reset clears valid bits and loads identity matrices and zero translation
// ----------------------------------------------------------------------------
// vertex_attribute_transform_top
// per-vertex position, normal, uv and tangent transform with apb config
// ----------------------------------------------------------------------------
`default_nettype none
`include "vertex_attribute_transform_top_macros.svh"

module vertex_attribute_transform_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [vat_pkg::AddrW-1:0] paddr,
  input  logic [vat_pkg::DataW-1:0] pwdata,
  output logic [vat_pkg::DataW-1:0] prdata,
  output logic                      pready,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [23:0]        pos_x_i,
  input  logic signed [23:0]        pos_y_i,
  input  logic signed [23:0]        pos_z_i,
  input  logic signed [15:0]        nrm_x_i,
  input  logic signed [15:0]        nrm_y_i,
  input  logic signed [15:0]        nrm_z_i,
  input  logic [31:0]               tex_uv_i,
  input  logic signed [15:0]        tan_x_i,
  input  logic signed [15:0]        tan_y_i,
  input  logic signed [15:0]        tan_z_i,
  input  logic                      tan_negative_i,
  input  logic [2:0]                present_mask_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [23:0]        out_pos_x_o,
  output logic signed [23:0]        out_pos_y_o,
  output logic signed [23:0]        out_pos_z_o,
  output logic signed [15:0]        out_nrm_x_o,
  output logic signed [15:0]        out_nrm_y_o,
  output logic signed [15:0]        out_nrm_z_o,
  output logic [31:0]               out_tex_uv_o,
  output logic signed [15:0]        out_tan_x_o,
  output logic signed [15:0]        out_tan_y_o,
  output logic signed [15:0]        out_tan_z_o,
  output logic signed [1:0]         out_tan_sign_o
);

  localparam int unsigned Lat  = vat_pkg::DirLat;
  localparam int unsigned PosD = Lat - 3;

  vat_pkg::cfg_t       cfg;
  vat_pkg::pipe_ctrl_t ctrl;
  logic [Lat-1:0]      vld_q;

  logic signed [23:0]  pos [3];
  logic signed [39:0]  pp_q [3][3];
  logic signed [41:0]  pacc_q [3];
  logic signed [23:0]  pr_q [3];
  logic signed [23:0]  posd_q [PosD][3];
  logic [31:0]         uv_q [Lat];
  logic [1:0]          sgn_q [Lat];
  logic                tanp_q [Lat];
  logic [31:0]         uv_d;
  logic signed [17:0]  fv;

  logic signed [15:0]  nvx, nvy, nvz;
  logic signed [15:0]  ndx, ndy, ndz, tdx, tdy, tdz;
  logic                nshort, tshort;
  logic                nrm_zero;
  logic                full_stall;

  vat_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign ctrl.adv   = !vld_q[Lat-1] || out_ready_i;
  assign ctrl.ld    = ctrl.adv || !vld_q[0];
  assign in_ready_o = ctrl.ld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (ctrl.ld) begin
        vld_q[0] <= in_valid_i;
      end
      if (ctrl.adv) begin
        vld_q[Lat-1:1] <= vld_q[Lat-2:0];
      end
    end
  end

  // position: products, sum with translation, round and saturate
  assign pos[0] = pos_x_i;
  assign pos[1] = pos_y_i;
  assign pos[2] = pos_z_i;

  always_ff @(posedge clk_i) begin
    if (ctrl.ld) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pp_q[i][j] <= vat_pkg::mat_entry(cfg.world[i], 2'(j)) * pos[j];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.adv) begin
      for (int i = 0; i < 3; i++) begin
        logic signed [23:0] t;
        logic signed [41:0] r;
        t = (i == 0) ? cfg.txy[47:24] : ((i == 1) ? cfg.txy[23:0] : cfg.tz);
        pacc_q[i] <= 42'(pp_q[i][0]) + 42'(pp_q[i][1]) + 42'(pp_q[i][2])
                   + 42'($signed({t, 12'h000}));
        r = pacc_q[i] + 42'sd2048;
        if ($signed(r[41:12]) > 30'sd8388607) begin
          pr_q[i] <= 24'sh7fffff;
        end else if ($signed(r[41:12]) < -30'sd8388608) begin
          pr_q[i] <= -24'sh800000;
        end else begin
          pr_q[i] <= r[35:12];
        end
      end
      for (int i = 0; i < 3; i++) begin
        posd_q[0][i] <= pr_q[i];
      end
      for (int k = 1; k < PosD; k++) begin
        for (int i = 0; i < 3; i++) begin
          posd_q[k][i] <= posd_q[k-1][i];
        end
      end
    end
  end

  // uv flip and tangent handedness
  assign fv = 18'sd4096 - 18'($signed(tex_uv_i[15:0]));
  always_comb begin
    if (!present_mask_i[1]) begin
      uv_d = '0;
    end else if (fv > 18'sd32767) begin
      uv_d = {tex_uv_i[31:16], 16'h7fff};
    end else begin
      uv_d = {tex_uv_i[31:16], fv[15:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.ld) begin
      uv_q[0]   <= uv_d;
      tanp_q[0] <= present_mask_i[2];
      sgn_q[0]  <= !present_mask_i[2] ? vat_pkg::TanSignNone :
                   (tan_negative_i ? vat_pkg::TanSignNeg : vat_pkg::TanSignPos);
    end
    if (ctrl.adv) begin
      for (int k = 1; k < Lat; k++) begin
        uv_q[k]   <= uv_q[k-1];
        tanp_q[k] <= tanp_q[k-1];
        sgn_q[k]  <= sgn_q[k-1];
      end
    end
  end

  // absent normal is taken as +z
  assign nvx = present_mask_i[0] ? nrm_x_i : 16'sd0;
  assign nvy = present_mask_i[0] ? nrm_y_i : 16'sd0;
  assign nvz = present_mask_i[0] ? nrm_z_i : vat_pkg::UnitQ14;

  vat_dir u_nrm (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .rows_i  (cfg.nrm),
    .vec_x_i (nvx),
    .vec_y_i (nvy),
    .vec_z_i (nvz),
    .dir_x_o (ndx),
    .dir_y_o (ndy),
    .dir_z_o (ndz),
    .short_o (nshort)
  );

  vat_dir u_tan (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .rows_i  (cfg.world),
    .vec_x_i (tan_x_i),
    .vec_y_i (tan_y_i),
    .vec_z_i (tan_z_i),
    .dir_x_o (tdx),
    .dir_y_o (tdy),
    .dir_z_o (tdz),
    .short_o (tshort)
  );

  assign out_valid_o    = vld_q[Lat-1];
  assign out_pos_x_o    = posd_q[PosD-1][0];
  assign out_pos_y_o    = posd_q[PosD-1][1];
  assign out_pos_z_o    = posd_q[PosD-1][2];
  assign out_nrm_x_o    = nshort ? 16'sd0 : ndx;
  assign out_nrm_y_o    = nshort ? 16'sd0 : ndy;
  assign out_nrm_z_o    = nshort ? vat_pkg::UnitQ14 : ndz;
  assign out_tex_uv_o   = uv_q[Lat-1];
  assign out_tan_x_o    = !tanp_q[Lat-1] ? 16'sd0 : (tshort ? vat_pkg::UnitQ14 : tdx);
  assign out_tan_y_o    = (!tanp_q[Lat-1] || tshort) ? 16'sd0 : tdy;
  assign out_tan_z_o    = (!tanp_q[Lat-1] || tshort) ? 16'sd0 : tdz;
  assign out_tan_sign_o = sgn_q[Lat-1];

  assign nrm_zero   = (out_nrm_x_o == 16'sd0) && (out_nrm_y_o == 16'sd0) &&
                      (out_nrm_z_o == 16'sd0);
  assign full_stall = out_valid_o && !out_ready_i && vld_q[0];

  `VAT_ASSERT_NEVER(a_tan_sign_code, out_valid_o && (out_tan_sign_o == 2'b10), "bad sign code")
  `VAT_ASSERT_IMPL(a_nrm_nonzero, out_valid_o, !nrm_zero, "zero normal")
  `VAT_ASSERT_IMPL(a_stall_full, full_stall, !in_ready_o, "item taken into full stalled pipe")

endmodule

`default_nettype wire

// ===== hw/rtl/vat_regs.sv =====
// ----------------------------------------------------------------------------
// vat_regs
// apb register file holding world, translation and normal matrices
// ----------------------------------------------------------------------------
`default_nettype none

module vat_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [vat_pkg::AddrW-1:0]   paddr,
  input  logic [vat_pkg::DataW-1:0]   pwdata,
  output logic [vat_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  output vat_pkg::cfg_t               cfg_o
);

  logic [2:0][47:0] world_q;
  logic [47:0]      txy_q;
  logic [23:0]      tz_q;
  logic [2:0][47:0] nrm_q;
  logic             wr;
  vat_pkg::reg_idx_e idx;

  assign wr     = psel & penable & pwrite;
  assign idx    = vat_pkg::reg_idx_e'(paddr[5:3]);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      // row 2 first, row 0 last
      world_q <= {48'h0000_0000_1000, 48'h0000_1000_0000, 48'h1000_0000_0000};
      nrm_q   <= {48'h0000_0000_1000, 48'h0000_1000_0000, 48'h1000_0000_0000};
      txy_q   <= '0;
      tz_q    <= '0;
    end else if (wr) begin
      unique case (idx)
        vat_pkg::REG_WORLD0: world_q[0] <= pwdata[47:0];
        vat_pkg::REG_WORLD1: world_q[1] <= pwdata[47:0];
        vat_pkg::REG_WORLD2: world_q[2] <= pwdata[47:0];
        vat_pkg::REG_TXY:    txy_q      <= pwdata[47:0];
        vat_pkg::REG_TZ:     tz_q       <= pwdata[23:0];
        vat_pkg::REG_NRM0:   nrm_q[0]   <= pwdata[47:0];
        vat_pkg::REG_NRM1:   nrm_q[1]   <= pwdata[47:0];
        vat_pkg::REG_NRM2:   nrm_q[2]   <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      vat_pkg::REG_WORLD0: prdata = 64'(world_q[0]);
      vat_pkg::REG_WORLD1: prdata = 64'(world_q[1]);
      vat_pkg::REG_WORLD2: prdata = 64'(world_q[2]);
      vat_pkg::REG_TXY:    prdata = 64'(txy_q);
      vat_pkg::REG_TZ:     prdata = 64'(tz_q);
      vat_pkg::REG_NRM0:   prdata = 64'(nrm_q[0]);
      vat_pkg::REG_NRM1:   prdata = 64'(nrm_q[1]);
      vat_pkg::REG_NRM2:   prdata = 64'(nrm_q[2]);
      default:             prdata = '0;
    endcase
  end

  assign cfg_o.world = world_q;
  assign cfg_o.txy   = txy_q;
  assign cfg_o.tz    = tz_q;
  assign cfg_o.nrm   = nrm_q;

endmodule

`default_nettype wire

// ===== hw/rtl/vat_isqrt.sv =====
// ----------------------------------------------------------------------------
// vat_isqrt
// pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module vat_isqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] x_i,
  output logic [31:0] root_o
);

  logic [31:0] root_q [vat_pkg::SqrtSteps];
  logic [33:0] rem_q  [vat_pkg::SqrtSteps];
  logic [63:0] xs_q   [vat_pkg::SqrtSteps];

  for (genvar k = 0; k < vat_pkg::SqrtSteps; k++) begin : g_step
    logic [31:0] root_in;
    logic [33:0] rem_in;
    logic [63:0] xs_in;
    logic [35:0] trial;
    logic [35:0] sub;
    if (k == 0) begin : g_first
      assign root_in = '0;
      assign rem_in  = '0;
      assign xs_in   = x_i;
    end else begin : g_next
      assign root_in = root_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign xs_in   = xs_q[k-1];
    end
    assign trial = {rem_in, xs_in[63:62]};
    assign sub   = {2'b00, root_in, 2'b01};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (trial >= sub) begin
          rem_q[k]  <= 34'(trial - sub);
          root_q[k] <= {root_in[30:0], 1'b1};
        end else begin
          rem_q[k]  <= trial[33:0];
          root_q[k] <= {root_in[30:0], 1'b0};
        end
        xs_q[k] <= {xs_in[61:0], 2'b00};
      end
    end
  end

  assign root_o = root_q[vat_pkg::SqrtSteps-1];

endmodule

`default_nettype wire

// ===== hw/rtl/vat_div.sv =====
// ----------------------------------------------------------------------------
// vat_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module vat_div (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [46:0] num_i,
  input  logic [31:0] den_i,
  output logic [14:0] quo_o
);

  logic [46:0] rem_q [vat_pkg::DivSteps];
  logic [31:0] den_q [vat_pkg::DivSteps];
  logic [14:0] quo_q [vat_pkg::DivSteps];

  for (genvar k = 0; k < vat_pkg::DivSteps; k++) begin : g_step
    logic [46:0] rem_in;
    logic [31:0] den_in;
    logic [14:0] quo_in;
    logic [46:0] dsh;
    if (k == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end
    assign dsh = 47'(den_in) << (vat_pkg::DivSteps - 1 - k);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_in >= dsh) begin
          rem_q[k] <= rem_in - dsh;
          quo_q[k] <= {quo_in[13:0], 1'b1};
        end else begin
          rem_q[k] <= rem_in;
          quo_q[k] <= {quo_in[13:0], 1'b0};
        end
        den_q[k] <= den_in;
      end
    end
  end

  assign quo_o = quo_q[vat_pkg::DivSteps-1];

endmodule

`default_nettype wire

// ===== hw/rtl/vat_dir.sv =====
// ----------------------------------------------------------------------------
// vat_dir
// direction path: 3x3 transform, round to q.16, length, normalize
// ----------------------------------------------------------------------------
`default_nettype none

module vat_dir (
  input  logic                     clk_i,
  input  vat_pkg::pipe_ctrl_t      ctrl_i,
  input  logic [2:0][47:0]         rows_i,
  input  logic signed [15:0]       vec_x_i,
  input  logic signed [15:0]       vec_y_i,
  input  logic signed [15:0]       vec_z_i,
  output logic signed [15:0]       dir_x_o,
  output logic signed [15:0]       dir_y_o,
  output logic signed [15:0]       dir_z_o,
  output logic                     short_o
);

  localparam int unsigned SqD = vat_pkg::SqrtSteps;
  localparam int unsigned DvD = vat_pkg::DivSteps;

  logic signed [15:0] vec [3];
  logic signed [31:0] prod_q [3][3];
  logic signed [23:0] c_q [3];
  logic signed [23:0] c2_q [3];
  logic [46:0]        sq_q [3];
  logic signed [23:0] c3_q [3];
  logic [47:0]        len2_q;
  logic               short3_q;
  logic signed [23:0] cd_q [SqD][3];
  logic               sd_q [SqD];
  logic [31:0]        root;
  logic [46:0]        num_q [3];
  logic [31:0]        den_q;
  logic               neg_q [DvD+1][3];
  logic               sh_q [DvD+1];
  logic [14:0]        quo [3];
  logic signed [15:0] dir_q [3];
  logic               short_q;

  assign vec[0] = vec_x_i;
  assign vec[1] = vec_y_i;
  assign vec[2] = vec_z_i;

  // matrix products
  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_q[i][j] <= vat_pkg::mat_entry(rows_i[i], 2'(j)) * vec[j];
        end
      end
    end
  end

  // row sums rounded half up to q.16, squares, squared length
  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      for (int i = 0; i < 3; i++) begin
        logic signed [33:0] s;
        logic signed [47:0] p;
        s = 34'(prod_q[i][0]) + 34'(prod_q[i][1]) + 34'(prod_q[i][2]) + 34'sd512;
        c_q[i]  <= s[33:10];
        p = c_q[i] * c_q[i];
        sq_q[i] <= p[46:0];
        c2_q[i] <= c_q[i];
        c3_q[i] <= c2_q[i];
      end
      len2_q   <= 48'(sq_q[0]) + 48'(sq_q[1]) + 48'(sq_q[2]);
      short3_q <= (48'(sq_q[0]) + 48'(sq_q[1]) + 48'(sq_q[2])) < vat_pkg::Len2Min;
    end
  end

  vat_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (ctrl_i.adv),
    .x_i    ({len2_q[47:0], 16'h0000}),
    .root_o (root)
  );

  // components ride alongside the root
  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      for (int i = 0; i < 3; i++) begin
        cd_q[0][i] <= c3_q[i];
      end
      sd_q[0] <= short3_q;
      for (int k = 1; k < SqD; k++) begin
        for (int i = 0; i < 3; i++) begin
          cd_q[k][i] <= cd_q[k-1][i];
        end
        sd_q[k] <= sd_q[k-1];
      end
    end
  end

  // numerators |c| * 2^22 + len / 2
  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      for (int i = 0; i < 3; i++) begin
        logic [23:0] mag;
        mag = cd_q[SqD-1][i][23] ? 24'(-cd_q[SqD-1][i]) : cd_q[SqD-1][i];
        num_q[i]    <= 47'({mag, 22'h0}) + 47'(root[31:1]);
        neg_q[0][i] <= cd_q[SqD-1][i][23];
      end
      den_q    <= root;
      sh_q[0]  <= sd_q[SqD-1];
      for (int k = 1; k <= DvD; k++) begin
        neg_q[k] <= neg_q[k-1];
        sh_q[k]  <= sh_q[k-1];
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    vat_div u_div (
      .clk_i (clk_i),
      .en_i  (ctrl_i.adv),
      .num_i (num_q[i]),
      .den_i (den_q),
      .quo_o (quo[i])
    );
  end

  // sign restore
  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      for (int i = 0; i < 3; i++) begin
        dir_q[i] <= neg_q[DvD][i] ? -$signed({1'b0, quo[i]}) : $signed({1'b0, quo[i]});
      end
      short_q <= sh_q[DvD];
    end
  end

  assign dir_x_o = dir_q[0];
  assign dir_y_o = dir_q[1];
  assign dir_z_o = dir_q[2];
  assign short_o = short_q;

endmodule

`default_nettype wire
